@@ design/frlt_pkg.sv @@
// Shared types and constants for the frame reassembly loss tracker.
// Used by the top level, the tracking core and the port checker; no dependencies.
package frlt_pkg;

   // Field widths fixed by the packet header format.
   localparam int unsigned FNUM_W   = 8;
   localparam int unsigned FTYPE_W  = 8;
   localparam int unsigned PCOUNT_W = 7;
   localparam int unsigned PIDX_W   = 8;
   localparam int unsigned PLEN_W   = 11;
   localparam int unsigned STRIDE_W = 11;
   localparam int unsigned MASK_W   = 64;
   localparam int unsigned OFFS_W   = 19;
   localparam int unsigned LEN_W    = 17;
   localparam int unsigned CNT16_W  = 16;
   localparam int unsigned EV_W     = 3;

   // Reset value of the packet slot stride.
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 11'd1430;

   // Frame type code of an I-frame.
   localparam logic [FTYPE_W-1:0] FTYPE_IFRAME = 8'd1;

   // Item kinds.
   localparam logic FUNC_DATA  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // Result event codes.
   localparam logic [EV_W-1:0] EV_DROP         = 3'd0;
   localparam logic [EV_W-1:0] EV_ACCEPT       = 3'd1;
   localparam logic [EV_W-1:0] EV_DONE         = 3'd2;
   localparam logic [EV_W-1:0] EV_QUERY_OTHER  = 3'd3;
   localparam logic [EV_W-1:0] EV_QUERY_NONE   = 3'd4;
   localparam logic [EV_W-1:0] EV_QUERY_MISSED = 3'd5;

   // One packet header or status query.
   typedef struct packed {
      logic                func;
      logic [FNUM_W-1:0]   frame_number;
      logic [FTYPE_W-1:0]  frame_type;
      logic [PCOUNT_W-1:0] packet_count;
      logic [PIDX_W-1:0]   packet_index;
      logic [PLEN_W-1:0]   payload_length;
   } req_type;

   // One result.
   typedef struct packed {
      logic [EV_W-1:0]     event_res;
      logic [FNUM_W-1:0]   current_frame;
      logic [MASK_W-1:0]   missing_mask;
      logic [PCOUNT_W-1:0] missing_count;
      logic [OFFS_W-1:0]   write_offset;
      logic [LEN_W-1:0]    frame_length;
      logic [FTYPE_W-1:0]  frame_kind;
      logic                deliver;
      logic [CNT16_W-1:0]  lost_frames;
      logic [CNT16_W-1:0]  good_frames;
   } rsp_type;

endpackage

@@ design/frlt_core.sv @@
// Frame tracking state and the combinational update for one item.
// Depends on frlt_pkg.
module frlt_core #(
   parameter int unsigned MAX_PACKETS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  frlt_pkg::req_type               item,
   input  logic [frlt_pkg::STRIDE_W-1:0]   stride,
   output frlt_pkg::rsp_type               result
);
   import frlt_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_PACKETS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PACKETS);
   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   // Tracking state.
   logic                   have_frame_ff,  have_frame_in;
   logic [FNUM_W-1:0]      cur_number_ff,  cur_number_in;
   logic [FTYPE_W-1:0]     cur_type_ff,    cur_type_in;
   logic [PCOUNT_W-1:0]    expected_ff,    expected_in;
   logic [PCOUNT_W-1:0]    received_ff,    received_in;
   logic [MAX_PACKETS-1:0] missing_ff,     missing_in;
   logic [CNT_W-1:0]       miss_cnt_ff,    miss_cnt_in;
   logic [LEN_W-1:0]       length_ff,      length_in;
   logic [FNUM_W-1:0]      prev_number_ff, prev_number_in;
   logic                   gop_ok_ff,      gop_ok_in;
   logic [CNT16_W-1:0]     lost_ff,        lost_in;
   logic [CNT16_W-1:0]     good_ff,        good_in;

   // Per-item helpers.
   logic [MAX_PACKETS-1:0] bit_sel;
   logic [MAX_PACKETS-1:0] new_mask;
   logic [CNT_W-1:0]       new_cnt;
   logic [MAX_PACKETS-1:0] base_bits;
   logic [CNT_W-1:0]       base_cnt;
   logic [PCOUNT_W-1:0]    base_recv;
   logic [LEN_W-1:0]       base_len;
   logic                   new_frame;
   logic                   accept;
   logic                   hit;
   logic [LEN_W:0]         len_sum;
   logic [OFFS_W-1:0]      offset;
   logic [FNUM_W:0]        prev_plus;
   logic                   is_iframe;
   logic [EV_W-1:0]        ev;
   logic                   dlv;

   // Bit of this packet and the fresh bitmap of a new frame.
   always_comb begin
      for (int i = 0; i < MAX_PACKETS; i++) begin
         bit_sel[i]  = (item.packet_index == PIDX_W'(i));
         new_mask[i] = (item.packet_count > PCOUNT_W'(i));
      end
      if (int'(item.packet_count) > MAX_PACKETS) begin
         new_cnt = MAX_CNT;
      end else begin
         new_cnt = CNT_W'(item.packet_count);
      end
   end

   // Buffer offset of the packet slot.
   assign offset = OFFS_W'(item.packet_index) * OFFS_W'(stride);

   // Next state and the result of this item.
   always_comb begin
      have_frame_in  = have_frame_ff;
      cur_number_in  = cur_number_ff;
      cur_type_in    = cur_type_ff;
      expected_in    = expected_ff;
      received_in    = received_ff;
      missing_in     = missing_ff;
      miss_cnt_in    = miss_cnt_ff;
      length_in      = length_ff;
      prev_number_in = prev_number_ff;
      gop_ok_in      = gop_ok_ff;
      lost_in        = lost_ff;
      good_in        = good_ff;
      ev             = EV_DROP;
      dlv            = 1'b0;

      new_frame = !have_frame_ff || (item.frame_number != cur_number_ff);
      base_bits = new_frame ? new_mask : missing_ff;
      base_cnt  = new_frame ? new_cnt : miss_cnt_ff;
      base_recv = new_frame ? '0 : received_ff;
      base_len  = new_frame ? '0 : length_ff;
      hit       = |(base_bits & bit_sel);
      accept    = new_frame || hit;
      len_sum   = {1'b0, base_len} + (LEN_W + 1)'(item.payload_length);
      is_iframe = 1'b0;
      prev_plus = {1'b0, prev_number_ff} + (FNUM_W + 1)'(1);

      if (item.func == FUNC_QUERY) begin
         // Status query: no state change.
         if (item.frame_number != cur_number_ff) begin
            ev = EV_QUERY_OTHER;
         end else if (|missing_ff) begin
            ev = EV_QUERY_MISSED;
         end else begin
            ev = EV_QUERY_NONE;
         end
      end else if (accept) begin
         if (new_frame) begin
            have_frame_in = 1'b1;
            cur_number_in = item.frame_number;
            cur_type_in   = item.frame_type;
            expected_in   = item.packet_count;
         end
         is_iframe   = (cur_type_in == FTYPE_IFRAME);
         missing_in  = base_bits & ~bit_sel;
         miss_cnt_in = base_cnt - CNT_W'(hit);
         received_in = base_recv + PCOUNT_W'(1);
         length_in   = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
         ev          = EV_ACCEPT;

         // Completion: sequence check and I-frame gating.
         if (received_in == expected_in) begin
            ev = EV_DONE;
            if (prev_plus == {1'b0, cur_number_in}) begin
               if (is_iframe) begin
                  gop_ok_in = 1'b1;
               end
               good_in = good_ff + CNT16_W'(1);
            end else if (cur_number_in == '0 && prev_number_ff == '1) begin
               if (is_iframe) begin
                  gop_ok_in = 1'b1;
               end
            end else begin
               lost_in   = lost_ff + CNT16_W'(1);
               gop_ok_in = is_iframe;
            end
            dlv            = gop_ok_in;
            prev_number_in = cur_number_in;
         end
      end
   end

   // Result fields show the state after this item.
   always_comb begin
      result.event_res     = ev;
      result.current_frame = cur_number_in;
      result.missing_mask  = MASK_W'(missing_in);
      result.missing_count = PCOUNT_W'(miss_cnt_in);
      result.write_offset  = (ev == EV_ACCEPT || ev == EV_DONE) ? offset : '0;
      result.frame_length  = length_in;
      result.frame_kind    = cur_type_in;
      result.deliver       = dlv;
      result.lost_frames   = lost_in;
      result.good_frames   = good_in;
   end

   // State registers advance once per processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         have_frame_ff  <= 1'b0;
         cur_number_ff  <= '0;
         cur_type_ff    <= '0;
         expected_ff    <= '0;
         received_ff    <= '0;
         missing_ff     <= '0;
         miss_cnt_ff    <= '0;
         length_ff      <= '0;
         prev_number_ff <= '0;
         gop_ok_ff      <= 1'b0;
         lost_ff        <= '0;
         good_ff        <= '0;
      end else if (step) begin
         have_frame_ff  <= have_frame_in;
         cur_number_ff  <= cur_number_in;
         cur_type_ff    <= cur_type_in;
         expected_ff    <= expected_in;
         received_ff    <= received_in;
         missing_ff     <= missing_in;
         miss_cnt_ff    <= miss_cnt_in;
         length_ff      <= length_in;
         prev_number_ff <= prev_number_in;
         gop_ok_ff      <= gop_ok_in;
         lost_ff        <= lost_in;
         good_ff        <= good_in;
      end
   end

endmodule

@@ design/frame_reassembly_loss_tracker.sv @@
// Frame reassembly loss tracker: input register, tracking core, result register.
// A request fills the input register; its response is registered when the item advances.
// One request per cycle unless rsp_ready stalls; the core updates all state at each advance.
// The input register takes a new transfer while a finished response still waits.
// Synchronous active-high reset clears both valid flags, all tracking state,
// and sets the packet stride to 1430. Depends on frlt_pkg and frlt_core.
module frame_reassembly_loss_tracker #(
   parameter int unsigned MAX_PACKETS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  frlt_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output frlt_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [frlt_pkg::STRIDE_W-1:0]   csr_data
);
   import frlt_pkg::*;

   logic                in_valid_ff, in_valid_in;
   req_type             in_data_ff;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_data_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic                advance;
   rsp_type             result;

   // The held item moves on when the result register is free or being drained.
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign csr_ready = 1'b1;

   frlt_core #(
      .MAX_PACKETS (MAX_PACKETS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_data_ff),
      .stride (stride_ff),
      .result (result)
   );

   // Control flags and the stride register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         stride_ff    <= STRIDE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            stride_ff <= csr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

endmodule

@@ design/frlt_checker.sv @@
// Port-level checker for the frame reassembly loss tracker, bound to the top level.
// Depends on frlt_pkg and frame_reassembly_loss_tracker.
module frlt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input frlt_pkg::rsp_type               rsp_data
);
   import frlt_pkg::*;

   // A stalled response transfer holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // No response is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Delivery is only signaled on a completed frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.deliver |-> rsp_data.event_res == EV_DONE)
      else $error("deliver without frame completion");

   // Dropped packets and queries carry no buffer offset.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_res == EV_DROP ||
                    rsp_data.event_res == EV_QUERY_OTHER ||
                    rsp_data.event_res == EV_QUERY_NONE ||
                    rsp_data.event_res == EV_QUERY_MISSED)
      |-> rsp_data.write_offset == '0)
      else $error("write offset on a non-accepting event");

   // The missing count is zero exactly when the bitmap is empty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.missing_mask == '0) == (rsp_data.missing_count == '0))
      else $error("missing count disagrees with bitmap");

endmodule

bind frame_reassembly_loss_tracker frlt_checker u_frlt_checker (.*);

@@ tb/sv/frame_reassembly_loss_tracker_tb.sv @@
// Self-checking testbench for the frame reassembly loss tracker.
// Drives packet headers and status queries, predicts every report, checks it.
// Depends on frlt_pkg and frame_reassembly_loss_tracker only.
`timescale 1ns / 100ps

module frame_reassembly_loss_tracker_tb;
   import frlt_pkg::*;

   // Cycles without any transfer before the run is declared hung.
   localparam int unsigned STALL_LIMIT = 2000;
   // Length of the long receiver hold-off.
   localparam int unsigned HOLD_CYCLES = 300;
   // Random headers per phase.
   localparam int unsigned PHASE_ITEMS = 190;

   typedef enum logic [1:0] {
      RCV_ALWAYS,
      RCV_RANDOM,
      RCV_PATTERN,
      RCV_COIN
   } rcv_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [STRIDE_W-1:0] csr_data = '0;

   // Own copy of the tracker state.
   logic                trk_open = 1'b0;
   logic [FNUM_W-1:0]   trk_frame = '0;
   logic [FTYPE_W-1:0]  trk_kind = '0;
   logic [PCOUNT_W-1:0] trk_needed = '0;
   logic [7:0]          trk_got = '0;
   logic [MASK_W-1:0]   trk_holes = '0;
   logic [LEN_W-1:0]    trk_bytes = '0;
   logic [FNUM_W-1:0]   trk_last = '0;
   logic                trk_gop = 1'b0;
   logic [CNT16_W-1:0]  trk_lost = '0;
   logic [CNT16_W-1:0]  trk_good = '0;
   logic [STRIDE_W-1:0] trk_stride = STRIDE_RESET;

   req_type headers_to_send[$];
   rsp_type expected_reports[$];
   int unsigned items_queued = 0;
   int unsigned items_accepted = 0;
   int unsigned mismatches = 0;
   int unsigned stalled_cycles = 0;
   logic req_xfer = 1'b0;

   // Stimulus controls, written by the sequencing block right after a rising edge.
   logic send_gappy = 1'b0;
   rcv_style_type rcv_style = RCV_ALWAYS;
   logic want_hold = 1'b0;
   logic [FNUM_W-1:0] stream_num = '0;

   frame_reassembly_loss_tracker i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Apply one accepted header to the tracker copy and return the report it causes.
   function automatic rsp_type track_header(input req_type h);
      rsp_type r;
      logic [MASK_W-1:0] slot;
      logic take;
      logic [LEN_W:0] sum;
      logic [FNUM_W:0] next_num;
      r = '0;
      r.event_res = EV_DROP;
      if (h.func == FUNC_QUERY) begin
         if (h.frame_number != trk_frame) begin
            r.event_res = EV_QUERY_OTHER;
         end else if (trk_holes != '0) begin
            r.event_res = EV_QUERY_MISSED;
         end else begin
            r.event_res = EV_QUERY_NONE;
         end
      end else begin
         slot = (h.packet_index < MASK_W) ? (64'd1 << h.packet_index) : '0;
         take = 1'b0;
         // A new frame number opens a frame with all of its packets missing.
         if (!trk_open || h.frame_number != trk_frame) begin
            trk_open = 1'b1;
            trk_frame = h.frame_number;
            trk_kind = h.frame_type;
            trk_needed = h.packet_count;
            trk_got = '0;
            trk_bytes = '0;
            trk_holes = (h.packet_count >= MASK_W) ? '1 : ((64'd1 << h.packet_count) - 64'd1);
            take = 1'b1;
         end else if ((trk_holes & slot) != '0) begin
            take = 1'b1;
         end
         if (take) begin
            trk_holes = trk_holes & ~slot;
            trk_got = trk_got + 8'd1;
            sum = {1'b0, trk_bytes} + h.payload_length;
            trk_bytes = sum[LEN_W] ? '1 : sum[LEN_W-1:0];
            r.write_offset = OFFS_W'(h.packet_index) * OFFS_W'(trk_stride);
            r.event_res = EV_ACCEPT;
            // Completion: continuity check, I-frame gating and the counters.
            if (trk_got == {1'b0, trk_needed}) begin
               r.event_res = EV_DONE;
               next_num = {1'b0, trk_last} + 9'd1;
               if (next_num != {1'b0, trk_frame}) begin
                  if (trk_frame == 8'd0 && trk_last == 8'd255) begin
                     if (trk_kind == FTYPE_IFRAME) trk_gop = 1'b1;
                  end else begin
                     trk_lost = trk_lost + 16'd1;
                     trk_gop = (trk_kind == FTYPE_IFRAME);
                  end
               end else begin
                  if (trk_kind == FTYPE_IFRAME) trk_gop = 1'b1;
                  trk_good = trk_good + 16'd1;
               end
               r.deliver = trk_gop;
               trk_last = trk_frame;
            end
         end
      end
      r.current_frame = trk_frame;
      r.missing_mask = trk_holes;
      r.missing_count = PCOUNT_W'($countones(trk_holes));
      r.frame_length = trk_bytes;
      r.frame_kind = trk_kind;
      r.lost_frames = trk_lost;
      r.good_frames = trk_good;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [MASK_W-1:0] want,
                                input logic [MASK_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_report(input rsp_type want, input rsp_type got);
      compare_field("event_res", MASK_W'(want.event_res), MASK_W'(got.event_res));
      compare_field("current_frame", MASK_W'(want.current_frame),
                    MASK_W'(got.current_frame));
      compare_field("missing_mask", want.missing_mask, got.missing_mask);
      compare_field("missing_count", MASK_W'(want.missing_count),
                    MASK_W'(got.missing_count));
      compare_field("write_offset", MASK_W'(want.write_offset), MASK_W'(got.write_offset));
      compare_field("frame_length", MASK_W'(want.frame_length), MASK_W'(got.frame_length));
      compare_field("frame_kind", MASK_W'(want.frame_kind), MASK_W'(got.frame_kind));
      compare_field("deliver", MASK_W'(want.deliver), MASK_W'(got.deliver));
      compare_field("lost_frames", MASK_W'(want.lost_frames), MASK_W'(got.lost_frames));
      compare_field("good_frames", MASK_W'(want.good_frames), MASK_W'(got.good_frames));
   endtask

   // Monitor: sample every transfer at the rising edge; reports are checked before
   // the header of the same edge is predicted, since a report always lags its header.
   always @(posedge clock) begin : transfer_monitor
      req_xfer = req_valid && req_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) trk_stride = csr_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $display("%0t ns: report with nothing expected, actual %h", $time, rsp_data);
               mismatches++;
            end else begin
               check_report(expected_reports.pop_front(), rsp_data);
            end
         end
         if (req_valid && req_ready) begin
            expected_reports.push_back(track_header(req_data));
            items_accepted++;
         end
         if ((csr_valid && csr_ready) || (rsp_valid && rsp_ready) || req_xfer) begin
            stalled_cycles = 0;
         end else begin
            stalled_cycles++;
         end
      end
   end

   // Driver: sends queued headers in bursts, with gaps between bursts when asked.
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;

   always @(negedge clock) begin : header_driver
      if (!req_valid || req_xfer) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (headers_to_send.size() != 0) begin
            req_data <= headers_to_send.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 12);
               gap_left = send_gappy ? $urandom_range(1, 8) : 0;
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stalls in the selected style, plus one long hold-off on request.
   logic [15:0] ready_pattern = 16'b1011_0011_1110_0101;
   logic hold_taken = 1'b0;
   int unsigned hold_left = 0;

   always @(negedge clock) begin : report_receiver
      if (want_hold && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (rcv_style)
            RCV_ALWAYS: rsp_ready <= 1'b1;
            RCV_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
            RCV_PATTERN: begin
               rsp_ready <= ready_pattern[0];
               ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            end
            default: rsp_ready <= ($urandom_range(0, 1) != 0);
         endcase
      end
   end

   function automatic req_type make_header(input logic f, input logic [FNUM_W-1:0] num,
                                           input logic [FTYPE_W-1:0] kind,
                                           input logic [PCOUNT_W-1:0] count,
                                           input logic [PIDX_W-1:0] idx,
                                           input logic [PLEN_W-1:0] len);
      req_type h;
      h.func = f;
      h.frame_number = num;
      h.frame_type = kind;
      h.packet_count = count;
      h.packet_index = idx;
      h.payload_length = len;
      return h;
   endfunction

   task automatic queue_header(input req_type h);
      headers_to_send.push_back(h);
      items_queued++;
   endtask

   // A query with junk in the fields it does not use.
   task automatic queue_query(input logic [FNUM_W-1:0] num);
      queue_header(make_header(FUNC_QUERY, num, FTYPE_W'($urandom_range(0, 255)),
                               PCOUNT_W'($urandom_range(0, 127)),
                               PIDX_W'($urandom_range(0, 255)),
                               PLEN_W'($urandom_range(0, 2047))));
   endtask

   // One frame in random packet order, sometimes with a lost or a repeated packet.
   task automatic queue_frame(input logic [FNUM_W-1:0] num, input logic [FTYPE_W-1:0] kind,
                              input logic [PCOUNT_W-1:0] count);
      int order[$];
      int n;
      int j;
      int tmp;
      n = (count > MASK_W) ? MASK_W : count;
      for (int i = 0; i < n; i++) order.push_back(i);
      for (int i = n - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      if (n > 1 && $urandom_range(0, 99) < 12) order.delete($urandom_range(0, order.size() - 1));
      if (n > 0 && $urandom_range(0, 99) < 20) begin
         tmp = order[$urandom_range(0, order.size() - 1)];
         order.insert($urandom_range(0, order.size()), tmp);
      end
      if (n == 0) order.push_back($urandom_range(0, 255));
      foreach (order[k]) begin
         queue_header(make_header(FUNC_DATA, num, kind, count, PIDX_W'(order[k]),
                                  PLEN_W'($urandom_range(0, 2047))));
         if ($urandom_range(0, 99) < 6) queue_query($urandom_range(0, 1) ? num : stream_num + 8'd7);
      end
   endtask

   // Mostly well-formed frames in a stream that is usually in sequence.
   task automatic queue_mixed(input int unsigned target);
      int unsigned sel;
      logic [FTYPE_W-1:0] kind;
      logic [PCOUNT_W-1:0] count;
      while (items_queued < target) begin
         sel = $urandom_range(0, 99);
         if (sel < 70) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) stream_num = stream_num + 8'd1;
            else if (sel < 88) stream_num = stream_num + 8'($urandom_range(2, 5));
            else if (sel < 95) stream_num = 8'($urandom_range(0, 255));
            else stream_num = 8'd254;
            sel = $urandom_range(0, 9);
            if (sel < 3) kind = FTYPE_IFRAME;
            else if (sel < 8) kind = FTYPE_W'($urandom_range(0, 3));
            else kind = FTYPE_W'($urandom_range(0, 255));
            sel = $urandom_range(0, 99);
            if (sel < 80) count = PCOUNT_W'($urandom_range(1, 8));
            else if (sel < 95) count = PCOUNT_W'($urandom_range(9, 63));
            else count = PCOUNT_W'(MASK_W);
            queue_frame(stream_num, kind, count);
         end else if (sel < 85) begin
            queue_query($urandom_range(0, 1) ? stream_num : 8'($urandom_range(0, 255)));
         end else begin
            queue_header(make_header(FUNC_DATA,
                                     $urandom_range(0, 1) ? stream_num : 8'($urandom_range(0, 255)),
                                     FTYPE_W'($urandom_range(0, 255)),
                                     PCOUNT_W'($urandom_range(0, 127)),
                                     PIDX_W'($urandom_range(0, 255)),
                                     PLEN_W'($urandom_range(0, 2047))));
         end
      end
   endtask

   // A frame whose count exceeds the bitmap, opened by an index outside it: 65 packets
   // of full length push the running length past its ceiling.
   task automatic queue_saturating_frame();
      stream_num = stream_num + 8'd1;
      queue_header(make_header(FUNC_DATA, stream_num, FTYPE_IFRAME, 7'd100, 8'd200, 11'd2047));
      for (int i = 0; i < MASK_W; i++) begin
         queue_header(make_header(FUNC_DATA, stream_num, FTYPE_IFRAME, 7'd100, PIDX_W'(i),
                                  11'd2047));
      end
   endtask

   task automatic wait_for_drain();
      do @(negedge clock); while (items_accepted != items_queued || expected_reports.size() != 0);
   endtask

   task automatic write_stride(input logic [STRIDE_W-1:0] value);
      @(negedge clock);
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Watchdog: end the run when nothing moves for too long.
   initial begin : stall_watchdog
      while (stalled_cycles < STALL_LIMIT) @(negedge clock);
      $display("frame_reassembly_loss_tracker regression: fail");
      $finish;
   end

   initial begin : sequencer
      int unsigned phase_base;
      logic [STRIDE_W-1:0] stride;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);
      send_gappy = 1'b1;
      rcv_style = RCV_RANDOM;

      // Directed headers under the reset stride.
      queue_header(make_header(FUNC_QUERY, 8'd0, 8'd0, 7'd0, 8'd0, 11'd0));
      queue_header(make_header(FUNC_QUERY, 8'hFF, 8'd0, 7'd0, 8'd0, 11'd0));
      queue_header(make_header(FUNC_DATA, 8'd0, FTYPE_IFRAME, 7'd3, 8'd0, 11'd2047));
      queue_header(make_header(FUNC_DATA, 8'd0, FTYPE_IFRAME, 7'd3, 8'd0, 11'd5));
      queue_header(make_header(FUNC_QUERY, 8'd0, 8'd0, 7'd0, 8'd0, 11'd0));
      queue_header(make_header(FUNC_DATA, 8'd0, FTYPE_IFRAME, 7'd3, 8'd255, 11'd0));
      queue_header(make_header(FUNC_DATA, 8'd0, FTYPE_IFRAME, 7'd3, 8'd3, 11'd0));
      queue_header(make_header(FUNC_DATA, 8'd0, FTYPE_IFRAME, 7'd3, 8'd2, 11'd0));
      queue_header(make_header(FUNC_DATA, 8'd0, FTYPE_IFRAME, 7'd3, 8'd1, 11'd1));
      queue_header(make_header(FUNC_QUERY, 8'd0, 8'd0, 7'd0, 8'd0, 11'd0));
      queue_header(make_header(FUNC_DATA, 8'd1, 8'd0, 7'd1, 8'd0, 11'd100));
      queue_header(make_header(FUNC_DATA, 8'd2, 8'hFF, 7'd0, 8'd0, 11'd7));
      queue_header(make_header(FUNC_DATA, 8'd2, 8'hFF, 7'd0, 8'd0, 11'd7));
      queue_header(make_header(FUNC_DATA, 8'd3, 8'd0, 7'd1, 8'd200, 11'd9));
      queue_header(make_header(FUNC_DATA, 8'd255, 8'd0, 7'd1, 8'd0, 11'd1));
      queue_header(make_header(FUNC_DATA, 8'd0, FTYPE_IFRAME, 7'd1, 8'd0, 11'd1));
      queue_header(make_header(FUNC_DATA, 8'd255, 8'd0, 7'd1, 8'd0, 11'd1));
      queue_header(make_header(FUNC_DATA, 8'd0, 8'd0, 7'd1, 8'd0, 11'd1));
      queue_header(make_header(FUNC_DATA, 8'd1, 8'd2, 7'd127, 8'd64, 11'd2047));
      queue_header(make_header(FUNC_DATA, 8'd1, 8'd2, 7'd127, 8'd63, 11'd2047));
      queue_header(make_header(FUNC_QUERY, 8'd1, 8'd0, 7'd0, 8'd0, 11'd0));
      queue_header(make_header(FUNC_DATA, 8'd2, FTYPE_IFRAME, 7'd64, 8'd63, 11'd3));
      queue_header(make_header(FUNC_QUERY, 8'hFF, 8'hFF, 7'h7F, 8'hFF, 11'h7FF));
      stream_num = 8'd2;

      // Random phases, each under its own stride and handshake style.
      for (int phase = 1; phase <= 6; phase++) begin
         wait_for_drain();
         repeat (4) @(posedge clock);
         case (phase)
            1: begin stride = 11'd1; send_gappy = 1'b1; rcv_style = RCV_RANDOM; end
            2: begin stride = 11'd2047; send_gappy = 1'b0; rcv_style = RCV_ALWAYS; end
            3: begin
               stride = STRIDE_W'($urandom_range(1, 2047));
               send_gappy = 1'b1;
               rcv_style = RCV_PATTERN;
            end
            4: begin stride = 11'd0; send_gappy = 1'b0; rcv_style = RCV_COIN; end
            5: begin
               stride = STRIDE_W'($urandom_range(1, 2047));
               send_gappy = 1'b1;
               rcv_style = RCV_RANDOM;
            end
            default: begin stride = STRIDE_RESET; send_gappy = 1'b0; rcv_style = RCV_ALWAYS; end
         endcase
         write_stride(stride);
         @(posedge clock);
         phase_base = items_queued;
         if (phase == 3) queue_saturating_frame();
         queue_mixed(phase_base + PHASE_ITEMS);
         // Hold the receiver off while the sender keeps offering headers.
         if (phase == 2) begin
            do @(negedge clock); while (items_accepted < phase_base + 40);
            @(posedge clock);
            want_hold = 1'b1;
         end
      end

      wait_for_drain();
      repeat (10) @(negedge clock);
      if (mismatches == 0) begin
         $display("frame_reassembly_loss_tracker regression: pass");
      end else begin
         $display("frame_reassembly_loss_tracker regression: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/frlt_pkg.sv
design/frlt_core.sv
design/frame_reassembly_loss_tracker.sv
design/frlt_checker.sv
tb/sv/frame_reassembly_loss_tracker_tb.sv
